/* design/gf2m_pkg.sv */
// shared types and constants for the gf(2^m) arithmetic unit
package gf2m_pkg;

   localparam int FIELD_DEGREE_DEF = 127;
   localparam int ELEM_W           = 127;
   localparam int LOW_W            = 64;
   localparam int HIGH_W           = 63;
   localparam int CSR_DATA_W       = 64;

   localparam logic [LOW_W-1:0]  TAIL_LOW_RESET  = 64'd3;
   localparam logic [HIGH_W-1:0] TAIL_HIGH_RESET = 63'd0;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_MUL = 2'd1,
      OP_SQR = 2'd2,
      OP_INV = 2'd3
   } opcode_type;

   typedef enum logic [0:0] {
      CSR_POLY_TAIL_LOW  = 1'b0,
      CSR_POLY_TAIL_HIGH = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_INV,
      ST_HOLD
   } fsm_state_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [LOW_W-1:0]   a_low;
      logic [HIGH_W-1:0]  a_high;
      logic [LOW_W-1:0]   b_low;
      logic [HIGH_W-1:0]  b_high;
   } req_payload_type;

   typedef struct packed {
      logic [LOW_W-1:0]   res_low;
      logic [HIGH_W-1:0]  res_high;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic mul_step;
      logic inv_step;
      logic capture;
   } ctl_type;

   typedef struct packed {
      logic deg_zero;
   } stat_type;

endpackage

/* design/gf2m_datapath.sv */
// shared shift and xor datapath for multiply, square, add and inverse
module gf2m_datapath
   import gf2m_pkg::*;
#(
   parameter int FIELD_DEGREE = FIELD_DEGREE_DEF
) (
   input  logic               clock,
   input  ctl_type            ctl,
   input  req_payload_type    req_data,
   input  logic [LOW_W-1:0]   tail_low,
   input  logic [HIGH_W-1:0]  tail_high,
   output stat_type           stat,
   output rsp_payload_type    res
);

   localparam int M     = FIELD_DEGREE;
   localparam int BW    = 2 * FIELD_DEGREE;
   localparam int DEG_W = $clog2(FIELD_DEGREE + 1);

   logic [M:0]       u_ff, u_in;
   logic [M:0]       v_ff, v_in;
   logic [BW-1:0]    bx_ff, bx_in;
   logic [BW-1:0]    cx_ff, cx_in;
   logic [DEG_W-1:0] du_ff, du_in;
   logic [DEG_W-1:0] dv_ff, dv_in;
   opcode_type       op_ff, op_in;

   logic [ELEM_W-1:0] a_full, b_full, tail_full, res_full;
   logic [M-1:0]      a_m, b_m, tail_m;
   logic [M:0]        poly;

   assign a_full    = {req_data.a_high, req_data.a_low};
   assign b_full    = {req_data.b_high, req_data.b_low};
   assign tail_full = {tail_high, tail_low};
   assign a_m       = a_full[M-1:0];
   assign b_m       = b_full[M-1:0];
   assign tail_m    = tail_full[M-1:0];
   assign poly      = {1'b1, tail_m};

   always_comb begin
      logic [M:0]    shl;
      logic [M:0]    t_u;
      logic [BW-1:0] t_b;
      logic          swap;
      u_in  = u_ff;
      v_in  = v_ff;
      bx_in = bx_ff;
      cx_in = cx_ff;
      du_in = du_ff;
      dv_in = dv_ff;
      op_in = op_ff;
      shl   = {u_ff[M-1:0], 1'b0};
      t_u   = u_ff ^ v_ff;
      t_b   = bx_ff ^ cx_ff;
      swap  = du_ff < dv_ff;
      if (ctl.load) begin
         op_in = req_data.opcode;
         case (req_data.opcode)
            OP_ADD: begin
               u_in = {1'b0, a_m ^ b_m};
            end
            OP_MUL: begin
               u_in  = '0;
               v_in  = {1'b0, a_m};
               cx_in = BW'(b_m);
            end
            OP_SQR: begin
               u_in  = '0;
               v_in  = {1'b0, a_m};
               cx_in = BW'(a_m);
            end
            OP_INV: begin
               u_in  = {1'b0, a_m};
               v_in  = poly;
               bx_in = BW'(1);
               cx_in = '0;
               du_in = DEG_W'(M);
               dv_in = DEG_W'(M);
            end
            default: begin
               u_in = u_ff;
            end
         endcase
      end else if (ctl.mul_step) begin
         // msb-first shift and add with on-the-fly reduction
         if (shl[M]) begin
            shl = shl ^ poly;
         end
         u_in  = shl ^ (cx_ff[M-1] ? v_ff : '0);
         cx_in = {cx_ff[BW-2:0], 1'b0};
      end else if (ctl.inv_step) begin
         if (u_ff[M]) begin
            // both aligned at the top: xor, swap roles if u has lower degree
            u_in  = {t_u[M-1:0], 1'b0};
            bx_in = {t_b[BW-2:0], 1'b0};
            v_in  = swap ? u_ff : v_ff;
            cx_in = swap ? bx_ff : cx_ff;
            du_in = (swap ? dv_ff : du_ff) - DEG_W'(1);
            dv_in = swap ? du_ff : dv_ff;
         end else begin
            u_in  = shl;
            bx_in = {bx_ff[BW-2:0], 1'b0};
            du_in = du_ff - DEG_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      u_ff  <= u_in;
      v_ff  <= v_in;
      bx_ff <= bx_in;
      cx_ff <= cx_in;
      du_ff <= du_in;
      dv_ff <= dv_in;
      op_ff <= op_in;
   end

   assign stat.deg_zero = (du_ff == '0);

   always_comb begin
      if (op_ff == OP_INV) begin
         res_full = ELEM_W'(bx_ff[BW-1:M]);
      end else begin
         res_full = ELEM_W'(u_ff[M-1:0]);
      end
   end

   assign res.res_low  = res_full[LOW_W-1:0];
   assign res.res_high = res_full[ELEM_W-1:LOW_W];

endmodule

/* design/gf2m_ctrl.sv */
// sequencer for the shared datapath
module gf2m_ctrl
   import gf2m_pkg::*;
#(
   parameter int FIELD_DEGREE = FIELD_DEGREE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  opcode_type req_opcode,
   input  logic       rsp_free,
   input  stat_type   stat,
   output logic       req_ready,
   output ctl_type    ctl
);

   localparam int DEG_W = $clog2(FIELD_DEGREE + 1);

   fsm_state_type    state_ff, state_in;
   logic [DEG_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_opcode)
                  OP_ADD:  state_in = ST_HOLD;
                  OP_MUL:  state_in = ST_MUL;
                  OP_SQR:  state_in = ST_MUL;
                  OP_INV:  state_in = ST_INV;
                  default: state_in = ST_HOLD;
               endcase
            end
         end
         ST_MUL: begin
            if (cnt_ff == '0) begin
               state_in = ST_HOLD;
            end
         end
         ST_INV: begin
            if (stat.deg_zero) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      ctl.load     = 1'b0;
      ctl.mul_step = 1'b0;
      ctl.inv_step = 1'b0;
      ctl.capture  = 1'b0;
      cnt_in       = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctl.load  = req_valid;
            cnt_in    = DEG_W'(FIELD_DEGREE - 1);
         end
         ST_MUL: begin
            ctl.mul_step = 1'b1;
            cnt_in       = cnt_ff - DEG_W'(1);
         end
         ST_INV: begin
            ctl.inv_step = !stat.deg_zero;
         end
         ST_HOLD: begin
            ctl.capture = rsp_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
   end

endmodule

/* design/gf2m_arithmetic_unit_top.sv */
// gf(2^m) arithmetic unit: add, multiply, square and inverse with a configurable polynomial
// multiply, square and inverse run one shift-and-xor step per cycle; add needs no step
// one transaction at a time; a new request is taken once the previous result is registered
// synchronous reset clears control state and sets the polynomial tail to x + 1
module gf2m_arithmetic_unit_top
   import gf2m_pkg::*;
#(
   parameter int FIELD_DEGREE = FIELD_DEGREE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [LOW_W-1:0]  tail_low_ff;
   logic [HIGH_W-1:0] tail_high_ff;
   logic              rsp_valid_ff;
   rsp_payload_type   rsp_data_ff;
   rsp_payload_type   res;
   ctl_type           ctl;
   stat_type          stat;
   logic              rsp_free;

   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   gf2m_ctrl #(
      .FIELD_DEGREE(FIELD_DEGREE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .rsp_free   (rsp_free),
      .stat       (stat),
      .req_ready  (req_ready),
      .ctl        (ctl)
   );

   gf2m_datapath #(
      .FIELD_DEGREE(FIELD_DEGREE)
   ) u_datapath (
      .clock     (clock),
      .ctl       (ctl),
      .req_data  (req_data),
      .tail_low  (tail_low_ff),
      .tail_high (tail_high_ff),
      .stat      (stat),
      .res       (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_low_ff  <= TAIL_LOW_RESET;
         tail_high_ff <= TAIL_HIGH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_POLY_TAIL_LOW:  tail_low_ff  <= csr_data;
            CSR_POLY_TAIL_HIGH: tail_high_ff <= csr_data[HIGH_W-1:0];
            default:            tail_low_ff  <= tail_low_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.capture) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         rsp_data_ff <= res;
      end
   end

endmodule
